/* src/bcc_pkg.sv */
package bcc_pkg;

   // widths fixed by the field layout
   localparam int BUTTON_W   = 3;
   localparam int NOW_W      = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int EVENT_W    = 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_TICKS   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DOUBLE_TICKS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOUNCE_TICKS = 2'd2;

   // configuration reset values
   localparam logic [CFG_W-1:0] LONG_TICKS_RST   = 16'd1000;
   localparam logic [CFG_W-1:0] DOUBLE_TICKS_RST = 16'd400;
   localparam logic [CFG_W-1:0] BOUNCE_TICKS_RST = 16'd50;

   // click event codes
   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
   localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
   localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

   typedef struct packed {
      logic [CFG_W-1:0] long_ticks;
      logic [CFG_W-1:0] double_ticks;
      logic [CFG_W-1:0] bounce_ticks;
   } bcc_cfg_type;

   typedef struct packed {
      logic last_level;
      logic action_pending;
      logic double_seen;
   } bcc_flags_type;

endpackage

/* src/bcc_req_if.sv */
interface bcc_req_if;
   logic                           valid;
   logic                           ready;
   logic [bcc_pkg::BUTTON_W-1:0]   button;
   logic                           level;
   logic [bcc_pkg::NOW_W-1:0]      now;

   modport source (output valid, output button, output level, output now, input ready);
   modport sink (input valid, input button, input level, input now, output ready);
endinterface

/* src/bcc_rsp_if.sv */
interface bcc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bcc_pkg::BUTTON_W-1:0]   button_out;
   logic [bcc_pkg::EVENT_W-1:0]    event_res;

   modport source (output valid, output button_out, output event_res, input ready);
   modport sink (input valid, input button_out, input event_res, output ready);
endinterface

/* src/button_click_classifier_core.sv */
// channel  | direction | payload                     | handshake
// ---------+-----------+-----------------------------+-------------------
// req_ch   | in        | button, level, now          | valid / ready
// rsp_ch   | out       | button_out, event_res       | valid / ready
// csr_*    | in        | csr_addr, csr_wdata         | csr_we, no wait
//
// one request per cycle sustained while rsp_ch is ready; a request is captured in the input register,
// classified out of it, and its result is held in the result register until it is taken
// per-button state is read and written back in the classify cycle, so requests for
// the same button may follow back to back
// reset clears flags to released / idle, zeroes deadlines and loads register defaults
// a stalled result holds the result register and, once the input register is full, req
module button_click_classifier_core #(
   parameter int BUTTONS   = 8,
   parameter int TICK_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   bcc_req_if.sink                          req_ch,
   bcc_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bcc_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   // configuration
   bcc_pkg::bcc_cfg_type cfg;

   // input register
   logic                            s1_valid_ff;
   logic [bcc_pkg::BUTTON_W-1:0]    s1_button_ff;
   logic                            s1_level_ff;
   logic [bcc_pkg::NOW_W-1:0]       s1_now_ff;

   // result register
   logic                            rsp_valid_ff;
   logic [bcc_pkg::BUTTON_W-1:0]    rsp_button_ff;
   logic [bcc_pkg::EVENT_W-1:0]     rsp_event_ff;

   // per-button state
   bcc_pkg::bcc_flags_type          flags_ff [BUTTONS];
   logic [TICK_BITS-1:0]            bounce_dl_ff [BUTTONS];
   logic [TICK_BITS-1:0]            double_dl_ff [BUTTONS];
   logic [TICK_BITS-1:0]            long_dl_ff [BUTTONS];

   // classification
   logic                            s1_go;
   logic                            req_take;
   logic                            in_range;
   logic [IDX_W-1:0]                idx;
   logic [TICK_BITS-1:0]            now_t;
   bcc_pkg::bcc_flags_type          flags_in;
   logic [TICK_BITS-1:0]            bounce_dl_in;
   logic [TICK_BITS-1:0]            double_dl_in;
   logic [TICK_BITS-1:0]            long_dl_in;
   logic [bcc_pkg::EVENT_W-1:0]     event_in;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance when the result register is empty or being taken this cycle
   assign s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_take     = req_ch.valid && req_ch.ready;

   // buttons beyond the configured count leave the state alone
   assign in_range = 32'(s1_button_ff) < 32'(BUTTONS);
   assign idx      = IDX_W'(s1_button_ff);
   assign now_t    = TICK_BITS'(s1_now_ff);

   bcc_classify #(
      .TICK_BITS (TICK_BITS)
   ) u_classify (
      .cfg           (cfg),
      .in_range      (in_range),
      .level         (s1_level_ff),
      .now           (now_t),
      .flags         (flags_ff[idx]),
      .bounce_dl     (bounce_dl_ff[idx]),
      .double_dl     (double_dl_ff[idx]),
      .long_dl       (long_dl_ff[idx]),
      .flags_nxt     (flags_in),
      .bounce_dl_nxt (bounce_dl_in),
      .double_dl_nxt (double_dl_in),
      .long_dl_nxt   (long_dl_in),
      .event_res     (event_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_button_ff <= req_ch.button;
         s1_level_ff  <= req_ch.level;
         s1_now_ff    <= req_ch.now;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_button_ff <= s1_button_ff;
         rsp_event_ff  <= event_in;
      end
   end

   // button flags: released and idle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            flags_ff[i].last_level     <= 1'b1;
            flags_ff[i].action_pending <= 1'b0;
            flags_ff[i].double_seen    <= 1'b0;
         end
      end else if (s1_go && in_range) begin
         flags_ff[idx] <= flags_in;
      end
   end

   // deadlines start at zero, so the first scan of a button is never in bounce
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            bounce_dl_ff[i] <= '0;
            double_dl_ff[i] <= '0;
            long_dl_ff[i]   <= '0;
         end
      end else if (s1_go && in_range) begin
         bounce_dl_ff[idx] <= bounce_dl_in;
         double_dl_ff[idx] <= double_dl_in;
         long_dl_ff[idx]   <= long_dl_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.button_out = rsp_button_ff;
   assign rsp_ch.event_res  = rsp_event_ff;

endmodule

/* src/bcc_csr.sv */
module bcc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bcc_pkg::CFG_W-1:0]        csr_wdata,
   output bcc_pkg::bcc_cfg_type             cfg
);

   bcc_pkg::bcc_cfg_type cfg_ff;
   bcc_pkg::bcc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            bcc_pkg::CSR_LONG_TICKS:   cfg_in.long_ticks   = csr_wdata;
            bcc_pkg::CSR_DOUBLE_TICKS: cfg_in.double_ticks = csr_wdata;
            bcc_pkg::CSR_BOUNCE_TICKS: cfg_in.bounce_ticks = csr_wdata;
            default:                   cfg_in = cfg_ff; // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_ticks   <= bcc_pkg::LONG_TICKS_RST;
         cfg_ff.double_ticks <= bcc_pkg::DOUBLE_TICKS_RST;
         cfg_ff.bounce_ticks <= bcc_pkg::BOUNCE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/bcc_classify.sv */
module bcc_classify #(
   parameter int TICK_BITS = 32
) (
   input  bcc_pkg::bcc_cfg_type              cfg,
   input  logic                              in_range,
   input  logic                              level,
   input  logic [TICK_BITS-1:0]              now,
   input  bcc_pkg::bcc_flags_type            flags,
   input  logic [TICK_BITS-1:0]              bounce_dl,
   input  logic [TICK_BITS-1:0]              double_dl,
   input  logic [TICK_BITS-1:0]              long_dl,
   output bcc_pkg::bcc_flags_type            flags_nxt,
   output logic [TICK_BITS-1:0]              bounce_dl_nxt,
   output logic [TICK_BITS-1:0]              double_dl_nxt,
   output logic [TICK_BITS-1:0]              long_dl_nxt,
   output logic [bcc_pkg::EVENT_W-1:0]       event_res
);

   logic bouncing;

   assign bouncing = now < bounce_dl;

   always_comb begin
      flags_nxt     = flags;
      bounce_dl_nxt = bounce_dl;
      double_dl_nxt = double_dl;
      long_dl_nxt   = long_dl;
      event_res     = bcc_pkg::EV_NONE;
      if (in_range && !bouncing) begin
         if (level != flags.last_level) begin
            if (!level) begin
               // press: deadlines come from the first press only
               if (!flags.action_pending) begin
                  long_dl_nxt   = now + TICK_BITS'(cfg.long_ticks);
                  double_dl_nxt = now + TICK_BITS'(cfg.double_ticks);
               end
            end else begin
               // release
               if ((now < double_dl) && flags.action_pending) begin
                  flags_nxt.double_seen = 1'b1;
               end
               flags_nxt.action_pending = 1'b1;
               bounce_dl_nxt = now + TICK_BITS'(cfg.bounce_ticks);
            end
            flags_nxt.last_level = level;
         end else if (flags.action_pending && (now > double_dl)) begin
            if (now > long_dl) begin
               event_res = bcc_pkg::EV_LONG;
            end else if (flags.double_seen) begin
               event_res = bcc_pkg::EV_DOUBLE;
            end else begin
               event_res = bcc_pkg::EV_SINGLE;
            end
            flags_nxt.action_pending = 1'b0;
            flags_nxt.double_seen    = 1'b0;
         end
      end
   end

endmodule

/* tb/sv/click_checker.sv */
`timescale 1ns / 1ps
module click_checker #(
   parameter int BUTTONS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   bcc_req_if                             req_mon,
   bcc_rsp_if                             rsp_mon,
   input  logic                           csr_we,
   input  logic [bcc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bcc_pkg::CFG_W-1:0]      csr_wdata,
   output int                             click_mismatches,
   output int                             clicks_owed
);

   typedef struct packed {
      logic [bcc_pkg::BUTTON_W-1:0] button;
      logic [bcc_pkg::EVENT_W-1:0]  click;
   } click_report_type;

   bcc_pkg::bcc_cfg_type       timing;
   logic                       was_released [BUTTONS];
   logic                       click_pending [BUTTONS];
   logic                       second_click [BUTTONS];
   logic [bcc_pkg::NOW_W-1:0]  bounce_until [BUTTONS];
   logic [bcc_pkg::NOW_W-1:0]  double_until [BUTTONS];
   logic [bcc_pkg::NOW_W-1:0]  long_until [BUTTONS];
   click_report_type           pending_clicks [$];
   int                         errors = 0;

   function automatic click_report_type classify_scan(
         input logic [bcc_pkg::BUTTON_W-1:0] btn,
         input logic lvl,
         input logic [bcc_pkg::NOW_W-1:0] now);
      click_report_type rep;
      rep.button = btn;
      rep.click  = bcc_pkg::EV_NONE;
      // ignored while bouncing
      if (now < bounce_until[btn]) return rep;
      if (lvl != was_released[btn]) begin
         if (!lvl) begin
            // a press while pending keeps the first press deadlines
            if (!click_pending[btn]) begin
               long_until[btn]   = now + bcc_pkg::NOW_W'(timing.long_ticks);
               double_until[btn] = now + bcc_pkg::NOW_W'(timing.double_ticks);
            end
         end else begin
            if (now < double_until[btn] && click_pending[btn]) second_click[btn] = 1'b1;
            click_pending[btn] = 1'b1;
            bounce_until[btn]  = now + bcc_pkg::NOW_W'(timing.bounce_ticks);
         end
         was_released[btn] = lvl;
      end else if (click_pending[btn] && now > double_until[btn]) begin
         if (now > long_until[btn])  rep.click = bcc_pkg::EV_LONG;
         else if (second_click[btn]) rep.click = bcc_pkg::EV_DOUBLE;
         else                        rep.click = bcc_pkg::EV_SINGLE;
         click_pending[btn] = 1'b0;
         second_click[btn]  = 1'b0;
      end
      return rep;
   endfunction

   always @(posedge clock) begin
      click_report_type want;
      if (reset) begin
         timing.long_ticks   = bcc_pkg::LONG_TICKS_RST;
         timing.double_ticks = bcc_pkg::DOUBLE_TICKS_RST;
         timing.bounce_ticks = bcc_pkg::BOUNCE_TICKS_RST;
         for (int b = 0; b < BUTTONS; b++) begin
            was_released[b]  = 1'b1;
            click_pending[b] = 1'b0;
            second_click[b]  = 1'b0;
            bounce_until[b]  = '0;
            double_until[b]  = '0;
            long_until[b]    = '0;
         end
         pending_clicks.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               bcc_pkg::CSR_LONG_TICKS:   timing.long_ticks = csr_wdata;
               bcc_pkg::CSR_DOUBLE_TICKS: timing.double_ticks = csr_wdata;
               bcc_pkg::CSR_BOUNCE_TICKS: timing.bounce_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_clicks.size() == 0) begin
               $error("unexpected result: button_out %0d, event_res %0d",
                      rsp_mon.button_out, rsp_mon.event_res);
               errors++;
            end else begin
               want = pending_clicks.pop_front();
               if (rsp_mon.button_out !== want.button) begin
                  $error("button_out: expected %0d, actual %0d", want.button, rsp_mon.button_out);
                  errors++;
               end
               if (rsp_mon.event_res !== want.click) begin
                  $error("event_res: expected %0d, actual %0d", want.click, rsp_mon.event_res);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_clicks.push_back(classify_scan(req_mon.button, req_mon.level, req_mon.now));
      end
      clicks_owed      <= pending_clicks.size();
      click_mismatches <= errors;
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

   localparam int BUTTONS = 8;
   // index with no register behind it, writes must be dropped
   localparam logic [bcc_pkg::CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we;
   logic [bcc_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [bcc_pkg::CFG_W-1:0]      csr_wdata;
   int                             click_mismatches;
   int                             clicks_owed;

   // idle odds in percent per cycle for the request and result sides
   int                             tx_idle_pct = 16;
   int                             rx_idle_pct = 77;
   int                             scans_sent = 0;
   // timing as last written, used to aim scan ticks at the thresholds
   bcc_pkg::bcc_cfg_type           cfg_now;
   logic [bcc_pkg::NOW_W-1:0]      tick;

   bcc_req_if req_ch ();
   bcc_rsp_if rsp_ch ();

   button_click_classifier_core #(
      .BUTTONS   (BUTTONS),
      .TICK_BITS (bcc_pkg::NOW_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   click_checker #(
      .BUTTONS (BUTTONS)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .click_mismatches (click_mismatches),
      .clicks_owed      (clicks_owed)
   );

   always #6 clock = ~clock;

   // result side stalls at random, odds set per phase
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // hard stop in case a result never shows up
   initial begin
      #(5_000_000);
      $display("testbench failed");
      $finish;
   end

   // one request, with random idle cycles ahead of it; returns at the accepting edge
   task automatic scan_button(input logic [bcc_pkg::BUTTON_W-1:0] btn, input logic lvl,
                              input logic [bcc_pkg::NOW_W-1:0] now);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.button <= btn;
      req_ch.level  <= lvl;
      req_ch.now    <= now;
      do @(posedge clock); while (!req_ch.ready);
      scans_sent++;
   endtask

   // drop valid and wait until every request has its result back
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (clicks_owed != 0);
   endtask

   // all three timing registers plus a junk write to the spare index
   task automatic load_timing(input logic [bcc_pkg::CFG_W-1:0] long_t,
                              input logic [bcc_pkg::CFG_W-1:0] double_t,
                              input logic [bcc_pkg::CFG_W-1:0] bounce_t);
      csr_we    <= 1'b1;
      csr_addr  <= bcc_pkg::CSR_LONG_TICKS;
      csr_wdata <= long_t;
      @(posedge clock);
      csr_addr  <= bcc_pkg::CSR_DOUBLE_TICKS;
      csr_wdata <= double_t;
      @(posedge clock);
      csr_addr  <= bcc_pkg::CSR_BOUNCE_TICKS;
      csr_wdata <= bounce_t;
      @(posedge clock);
      csr_addr  <= CSR_SPARE;
      csr_wdata <= bcc_pkg::CFG_W'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_now.long_ticks   = long_t;
      cfg_now.double_ticks = double_t;
      cfg_now.bounce_ticks = bounce_t;
   endtask

   // next scan tick, often right at a bounce, double or long boundary (one tick either side)
   function automatic logic [bcc_pkg::NOW_W-1:0] next_tick(
         input logic [bcc_pkg::NOW_W-1:0] press_t,
         input logic [bcc_pkg::NOW_W-1:0] release_t);
      logic [bcc_pkg::NOW_W-1:0] aim;
      case ($urandom_range(6))
         0:       aim = tick + $urandom_range(3);
         1:       aim = release_t + cfg_now.bounce_ticks + $urandom_range(2) - 1;
         2:       aim = press_t + cfg_now.double_ticks + $urandom_range(2) - 1;
         3:       aim = press_t + cfg_now.long_ticks + $urandom_range(2) - 1;
         4:       aim = tick + $urandom_range(cfg_now.bounce_ticks + 1);
         5:       aim = tick + $urandom_range(cfg_now.double_ticks + 1);
         default: aim = tick + $urandom_range(2 * cfg_now.long_ticks + 4);
      endcase
      // time only moves forward here, late scans come from the noise requests
      return (aim < tick) ? tick + $urandom_range(1) : aim;
   endfunction

   // one or two presses with held scans, then a scan late enough to get the click reported
   task automatic click_burst(input logic [bcc_pkg::BUTTON_W-1:0] btn);
      int                        presses;
      logic [bcc_pkg::NOW_W-1:0] press_t;
      logic [bcc_pkg::NOW_W-1:0] release_t;
      presses   = ($urandom_range(2) == 0) ? 2 : 1;
      press_t   = tick;
      release_t = tick;
      for (int p = 0; p < presses; p++) begin
         tick = next_tick(press_t, release_t);
         scan_button(btn, 1'b0, tick);
         if (p == 0) press_t = tick;
         repeat ($urandom_range(2)) begin
            tick = next_tick(press_t, release_t);
            scan_button(btn, 1'b0, tick);
         end
         tick = next_tick(press_t, release_t);
         scan_button(btn, 1'b1, tick);
         release_t = tick;
         repeat ($urandom_range(1, 3)) begin
            tick = next_tick(press_t, release_t);
            scan_button(btn, 1'b1, tick);
         end
      end
      tick = tick + cfg_now.long_ticks + cfg_now.double_ticks + cfg_now.bounce_ticks + 2;
      scan_button(btn, 1'b1, tick);
   endtask

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.button <= '0;
      req_ch.level  <= 1'b1;
      req_ch.now    <= '0;
      csr_we        <= 1'b0;
      csr_addr      <= bcc_pkg::CSR_LONG_TICKS;
      csr_wdata     <= '0;
      cfg_now.long_ticks   = bcc_pkg::LONG_TICKS_RST;
      cfg_now.double_ticks = bcc_pkg::DOUBLE_TICKS_RST;
      cfg_now.bounce_ticks = bcc_pkg::BOUNCE_TICKS_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on reset timing: long 1000, double 400, bounce 50
      // idle scan, press, held press, release, scan inside bounce
      scan_button(3'd0, 1'b1, 32'd0);
      scan_button(3'd0, 1'b0, 32'd100);
      scan_button(3'd0, 1'b0, 32'd200);
      scan_button(3'd0, 1'b1, 32'd300);
      scan_button(3'd0, 1'b1, 32'd320);
      // second press while pending keeps the first deadlines, release inside window
      scan_button(3'd0, 1'b0, 32'd360);
      scan_button(3'd0, 1'b1, 32'd420);
      // exactly at the double deadline nothing yet, one tick later a double click
      scan_button(3'd0, 1'b1, 32'd500);
      scan_button(3'd0, 1'b1, 32'd501);
      // long click, reported on the first scan after bounce ends
      scan_button(3'd1, 1'b0, 32'd1000);
      scan_button(3'd1, 1'b0, 32'd2000);
      scan_button(3'd1, 1'b1, 32'd2100);
      scan_button(3'd1, 1'b1, 32'd2150);
      // single click
      scan_button(3'd2, 1'b0, 32'd5000);
      scan_button(3'd2, 1'b1, 32'd5100);
      scan_button(3'd2, 1'b1, 32'd5401);
      // deadlines wrap past the top of the tick range and count as passed
      scan_button(3'd3, 1'b0, 32'hFFFF_FF00);
      scan_button(3'd3, 1'b1, 32'hFFFF_FFFF);
      scan_button(3'd3, 1'b1, 32'hFFFF_FFFF);
      // remaining indexes and alternating tick bits
      scan_button(3'd4, 1'b0, 32'h5555_5555);
      scan_button(3'd4, 1'b0, 32'hAAAA_AAAA);
      scan_button(3'd5, 1'b0, 32'd1);
      scan_button(3'd6, 1'b1, 32'd2);
      scan_button(3'd7, 1'b0, 32'h1234_5678);
      settle();

      // random part, well above every deadline left by the directed requests
      tick = 32'h6000_0000 + $urandom_range(32'h0FFF_FFFF);
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       load_timing(16'd40, 16'd20, 16'd5);
            1:       load_timing(16'd0, 16'd0, 16'd0);
            2:       load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
            3:       load_timing(16'd10, 16'd30, 16'd0);
            4:       load_timing(bcc_pkg::CFG_W'($urandom_range(300)),
                                 bcc_pkg::CFG_W'($urandom_range(300)),
                                 bcc_pkg::CFG_W'($urandom_range(60)));
            default: load_timing(bcc_pkg::LONG_TICKS_RST, bcc_pkg::DOUBLE_TICKS_RST,
                                 bcc_pkg::BOUNCE_TICKS_RST);
         endcase
         // sender idles lightly first, then the receiver, then nobody
         tx_idle_pct = (ph < 2) ? 16 : ((ph < 4) ? 77 : 0);
         rx_idle_pct = (ph < 2) ? 77 : ((ph < 4) ? 16 : 0);
         // jump clear of every deadline from the previous phase
         tick = tick + $urandom_range(32'h0100_0000, 32'h0010_0000);
         while (scans_sent < 24 + (ph + 1) * 275) begin
            if ($urandom_range(9) < 8) begin
               click_burst(bcc_pkg::BUTTON_W'($urandom_range(BUTTONS - 1)));
            end else begin
               // stray request on any button, often landing inside a bounce
               scan_button(bcc_pkg::BUTTON_W'($urandom_range(BUTTONS - 1)),
                           1'($urandom_range(1)),
                           tick - $urandom_range(cfg_now.bounce_ticks + 2));
            end
         end
         settle();
      end

      // let any stray result surface before the verdict
      repeat (4) @(posedge clock);
      if (click_mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/bcc_pkg.sv
src/bcc_req_if.sv
src/bcc_rsp_if.sv
src/bcc_csr.sv
src/bcc_classify.sv
src/button_click_classifier_core.sv
tb/sv/click_checker.sv
tb/sv/testbench.sv
